// ===== rtl/efcc_pkg.sv =====
// shared types and constants for the elevator call controller
package efcc_pkg;

  localparam int FLOOR_W = 4;
  localparam int QDEPTH = 16;
  localparam int QAW = $clog2(QDEPTH);
  localparam int CNT_W = QAW + 1;
  localparam logic [CNT_W-1:0] QFULL = CNT_W'(QDEPTH);

  localparam int NUM_FLOORS_DEF = 16;
  localparam int START_LEVEL_DEF = 0;

  typedef enum logic [1:0] {
    OP_CALL    = 2'd0,
    OP_REACHED = 2'd1,
    OP_CLOSED  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CABIN = 2'd1,
    MODE_DOORS = 2'd2
  } mode_t;

  typedef struct packed {
    logic               move_cabin;
    logic               stop_cabin;
    logic               free_cabin;
    logic               serviced_valid;
    logic [FLOOR_W-1:0] serviced_floor;
    logic               floor_changed;
    logic [FLOOR_W-1:0] current_floor;
    logic [1:0]         ctrl_state;
    logic [CNT_W-1:0]   pending_count;
  } res_t;

  typedef struct packed {
    logic               rd_en;
    logic [QAW-1:0]     rd_addr;
    logic               wr_en;
    logic [QAW-1:0]     wr_addr;
    logic [FLOOR_W-1:0] wr_data;
  } mem_req_t;

  // highest reachable floor, bounded by the floor field width
  function automatic int top_floor(input int num_floors);
    int n;
    n = num_floors;
    if (n < 1) n = 1;
    if (n > (1 << FLOOR_W)) n = 1 << FLOOR_W;
    return n - 1;
  endfunction

endpackage

// ===== rtl/efcc_if.sv =====
// event and result channel interfaces of the elevator call controller
interface efcc_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [efcc_pkg::FLOOR_W-1:0]    call_floor;

  modport source (output valid, output opcode, output call_floor, input ready);
  modport sink (input valid, input opcode, input call_floor, output ready);
endinterface

interface efcc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            move_cabin;
  logic                            stop_cabin;
  logic                            free_cabin;
  logic                            serviced_valid;
  logic [efcc_pkg::FLOOR_W-1:0]    serviced_floor;
  logic                            floor_changed;
  logic [efcc_pkg::FLOOR_W-1:0]    current_floor;
  logic [1:0]                      ctrl_state;
  logic [efcc_pkg::CNT_W-1:0]      pending_count;

  modport source (output valid, output move_cabin, output stop_cabin, output free_cabin,
                  output serviced_valid, output serviced_floor, output floor_changed,
                  output current_floor, output ctrl_state, output pending_count,
                  input ready);
  modport sink (input valid, input move_cabin, input stop_cabin, input free_cabin,
                input serviced_valid, input serviced_floor, input floor_changed,
                input current_floor, input ctrl_state, input pending_count,
                output ready);
endinterface

// ===== rtl/elevator_fifo_call_controller.sv =====
// top level of the elevator call controller with its result register
//
//   channel | dir | signals                                  | transfer when
//   in_ch   | in  | opcode, call_floor                       | valid && ready
//   out_ch  | out | commands, serviced floor, floor, state,  | valid && ready
//           |     | pending count                            |
//
// steps: floor reached, ignored events and a call to the cabin floor while idle go straight to done;
// doors closed pops the head and, if entries remain, reads the next one for routing; any other call
// scans the queued entries one at a time, inserts, and from idle reads the new head back for routing.
// the single read port of the call queue memory walked by the scan sets the call length.
// reset: synchronous, active low; no clearing pass, queue entries are only read
// inside the pending count. a result waits in the output register while the next
// event is taken; the sequencer holds a finished result only when that register
// is still occupied.
module elevator_fifo_call_controller #(
  parameter int NUM_FLOORS  = efcc_pkg::NUM_FLOORS_DEF,
  parameter int START_LEVEL = efcc_pkg::START_LEVEL_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  efcc_in_if.sink    in_ch,
  efcc_out_if.source out_ch
);

  logic                         res_valid;
  logic                         res_ready;
  efcc_pkg::res_t               res;
  efcc_pkg::mem_req_t           mem_req;
  logic [efcc_pkg::FLOOR_W-1:0] rd_data;
  logic                         out_valid_r;
  efcc_pkg::res_t               out_data_r;

  efcc_ctrl #(
    .NUM_FLOORS  (NUM_FLOORS),
    .START_LEVEL (START_LEVEL)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .in_floor  (in_ch.call_floor),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  efcc_qmem u_qmem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.move_cabin     = out_data_r.move_cabin;
  assign out_ch.stop_cabin     = out_data_r.stop_cabin;
  assign out_ch.free_cabin     = out_data_r.free_cabin;
  assign out_ch.serviced_valid = out_data_r.serviced_valid;
  assign out_ch.serviced_floor = out_data_r.serviced_floor;
  assign out_ch.floor_changed  = out_data_r.floor_changed;
  assign out_ch.current_floor  = out_data_r.current_floor;
  assign out_ch.ctrl_state     = out_data_r.ctrl_state;
  assign out_ch.pending_count  = out_data_r.pending_count;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res.pending_count <= efcc_pkg::QFULL)
    else $error("pending count above queue depth");

  a_no_accept_while_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ch.ready)
    else $error("event taken while a result is pending in the sequencer");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_ch.valid)
    else $error("finished result not loaded into output register");

  a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stop_cabin |-> out_ch.ctrl_state == efcc_pkg::MODE_DOORS)
    else $error("stop commanded outside waiting for doors");

  a_move_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.move_cabin |-> out_ch.ctrl_state == efcc_pkg::MODE_CABIN)
    else $error("move commanded outside waiting for cabin");

endmodule

// ===== rtl/efcc_qmem.sv =====
// call queue storage: one write port, one registered read port
module efcc_qmem (
  input  logic                         clk,
  input  efcc_pkg::mem_req_t           req,
  output logic [efcc_pkg::FLOOR_W-1:0] rd_data
);

  logic [efcc_pkg::FLOOR_W-1:0] mem [efcc_pkg::QDEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/efcc_ctrl.sv =====
// event sequencer: duplicate scan, queue update, routing and cabin tracking
module efcc_ctrl #(
  parameter int NUM_FLOORS  = efcc_pkg::NUM_FLOORS_DEF,
  parameter int START_LEVEL = efcc_pkg::START_LEVEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic [efcc_pkg::FLOOR_W-1:0] in_floor,
  output logic                         res_valid,
  input  logic                         res_ready,
  output efcc_pkg::res_t               res,
  output efcc_pkg::mem_req_t           mem_req,
  input  logic [efcc_pkg::FLOOR_W-1:0] rd_data
);

  localparam int FW = efcc_pkg::FLOOR_W;
  localparam int AW = efcc_pkg::QAW;
  localparam int CW = efcc_pkg::CNT_W;
  localparam int TopInt = efcc_pkg::top_floor(NUM_FLOORS);
  localparam int StartInt = (START_LEVEL > TopInt) ? TopInt : START_LEVEL;
  localparam logic [FW-1:0] TopFloor = FW'(TopInt);
  localparam logic [FW-1:0] StartFloor = FW'(StartInt);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_INSERT = 7'b0000100,
    ST_POP    = 7'b0001000,
    ST_RDHEAD = 7'b0010000,
    ST_ROUTE  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [FW-1:0]       flr_r, flr_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                dup_r, dup_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  efcc_pkg::mode_t     mode_r, mode_nxt;
  logic                up_r, up_nxt;
  logic [FW-1:0]       cabin_r, cabin_nxt;
  logic [FW-1:0]       goal_r, goal_nxt;
  logic                mv_r, mv_nxt;
  logic                stp_r, stp_nxt;
  logic                frc_r, frc_nxt;
  logic                sv_r, sv_nxt;
  logic [FW-1:0]       sf_r, sf_nxt;
  logic                fc_r, fc_nxt;
  logic [FW-1:0]       cabin_step;

  always_comb begin
    if (up_r) begin
      cabin_step = (cabin_r < TopFloor) ? cabin_r + FW'(1) : cabin_r;
    end else begin
      cabin_step = (cabin_r != '0) ? cabin_r - FW'(1) : cabin_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    flr_nxt   = flr_r;
    idx_nxt   = idx_r;
    dup_nxt   = dup_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    mode_nxt  = mode_r;
    up_nxt    = up_r;
    cabin_nxt = cabin_r;
    goal_nxt  = goal_r;
    mv_nxt    = mv_r;
    stp_nxt   = stp_r;
    frc_nxt   = frc_r;
    sv_nxt    = sv_r;
    sf_nxt    = sf_r;
    fc_nxt    = fc_r;
    mem_req   = '0;
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          flr_nxt   = in_floor;
          idx_nxt   = '0;
          dup_nxt   = 1'b0;
          mv_nxt    = 1'b0;
          stp_nxt   = 1'b0;
          frc_nxt   = 1'b0;
          sv_nxt    = 1'b0;
          sf_nxt    = '0;
          fc_nxt    = 1'b0;
          state_nxt = ST_DONE;
          unique case (in_opcode)
            efcc_pkg::OP_CALL: begin
              if (in_floor <= TopFloor) begin
                if (in_floor == cabin_r && mode_r == efcc_pkg::MODE_IDLE) begin
                  mode_nxt = efcc_pkg::MODE_DOORS;
                  stp_nxt  = 1'b1;
                end else if (count_r != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_r;
                  state_nxt       = ST_SCAN;
                end else begin
                  state_nxt = ST_INSERT;
                end
              end
            end
            efcc_pkg::OP_REACHED: begin
              if (mode_r == efcc_pkg::MODE_CABIN) begin
                cabin_nxt = cabin_step;
                fc_nxt    = 1'b1;
                if (cabin_step != goal_r) begin
                  mv_nxt = 1'b1;
                end else begin
                  mode_nxt = efcc_pkg::MODE_DOORS;
                  stp_nxt  = 1'b1;
                end
              end
            end
            efcc_pkg::OP_CLOSED: begin
              if (mode_r == efcc_pkg::MODE_DOORS) begin
                frc_nxt = 1'b1;
                if (count_r != '0) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_r;
                  state_nxt       = ST_POP;
                end else begin
                  mode_nxt = efcc_pkg::MODE_IDLE;
                  up_nxt   = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // rd_data holds queue entry idx_r
        if (rd_data == flr_r) begin
          dup_nxt   = 1'b1;
          state_nxt = ST_INSERT;
        end else if ({1'b0, idx_r} + CW'(1) < count_r) begin
          idx_nxt         = idx_r + AW'(1);
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = head_r + idx_r + AW'(1);
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (!dup_r && count_r < efcc_pkg::QFULL) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = head_r + count_r[AW-1:0];
          mem_req.wr_data = flr_r;
          count_nxt       = count_r + CW'(1);
        end
        // the head read goes out in the cycle after the write so it sees the new entry
        state_nxt = (mode_r == efcc_pkg::MODE_IDLE) ? ST_RDHEAD : ST_DONE;
      end
      ST_POP: begin
        sv_nxt    = 1'b1;
        sf_nxt    = rd_data;
        head_nxt  = head_r + AW'(1);
        count_nxt = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          mode_nxt  = efcc_pkg::MODE_IDLE;
          up_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = head_r + AW'(1);
          state_nxt       = ST_ROUTE;
        end
      end
      ST_RDHEAD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = head_r;
        state_nxt       = ST_ROUTE;
      end
      ST_ROUTE: begin
        goal_nxt = rd_data;
        if (rd_data == cabin_r) begin
          mode_nxt = efcc_pkg::MODE_DOORS;
          stp_nxt  = 1'b1;
        end else begin
          up_nxt   = (rd_data > cabin_r);
          mode_nxt = efcc_pkg::MODE_CABIN;
          mv_nxt   = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      mode_r  <= efcc_pkg::MODE_IDLE;
      up_r    <= 1'b0;
      cabin_r <= StartFloor;
      goal_r  <= StartFloor;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
      up_r    <= up_nxt;
      cabin_r <= cabin_nxt;
      goal_r  <= goal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flr_r <= flr_nxt;
    idx_r <= idx_nxt;
    dup_r <= dup_nxt;
    mv_r  <= mv_nxt;
    stp_r <= stp_nxt;
    frc_r <= frc_nxt;
    sv_r  <= sv_nxt;
    sf_r  <= sf_nxt;
    fc_r  <= fc_nxt;
  end

  always_comb begin
    res.move_cabin     = mv_r;
    res.stop_cabin     = stp_r;
    res.free_cabin     = frc_r;
    res.serviced_valid = sv_r;
    res.serviced_floor = sf_r;
    res.floor_changed  = fc_r;
    res.current_floor  = cabin_r;
    res.ctrl_state     = mode_r;
    res.pending_count  = count_r;
  end

endmodule

// ===== bench/elevator_fifo_call_controller_test.sv =====
`timescale 1ns / 100ps
// testbench for the elevator call controller: directed event table, then random event traffic
module elevator_fifo_call_controller_test;

  localparam int FLOOR_W = efcc_pkg::FLOOR_W;
  localparam int QDEPTH = efcc_pkg::QDEPTH;
  localparam int QAW = efcc_pkg::QAW;
  localparam int CNT_W = efcc_pkg::CNT_W;
  localparam int FLOORS = efcc_pkg::NUM_FLOORS_DEF;
  localparam int START = efcc_pkg::START_LEVEL_DEF;
  localparam int FLOOR_SPAN = (FLOORS < 1) ? 1 : ((FLOORS > 16) ? 16 : FLOORS);
  localparam int TOP_FLOOR = FLOOR_SPAN - 1;
  localparam int HOME_FLOOR = (START > TOP_FLOOR) ? TOP_FLOOR : START;
  localparam logic [FLOOR_W-1:0] HOME4 = FLOOR_W'(HOME_FLOOR);
  localparam logic [FLOOR_W-1:0] TOP4 = FLOOR_W'(TOP_FLOOR);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_EVENTS = 1100;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_MOVE,
    CMD_STOP
  } cmd_t;

  typedef struct {
    logic [1:0]         op;
    logic [FLOOR_W-1:0] call_fl;
    int                 reps;
    bit                 typed;
    efcc_pkg::res_t     want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  efcc_in_if  in_ch ();
  efcc_out_if out_ch ();

  elevator_fifo_call_controller #(
    .NUM_FLOORS (FLOORS),
    .START_LEVEL(START)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted controller state
  logic [FLOOR_W-1:0] call_ring [QDEPTH];
  logic [QAW-1:0]     ring_head;
  logic [CNT_W-1:0]   ring_count;
  efcc_pkg::mode_t    car_mode;
  logic               heading_up;
  logic [FLOOR_W-1:0] car_floor;
  logic [FLOOR_W-1:0] goal_floor;

  efcc_pkg::res_t expected_status_q [$];
  int   errors = 0;
  int   burst_left = 0;

  task automatic reset_model();
    foreach (call_ring[i]) call_ring[i] = '0;
    ring_head = '0;
    ring_count = '0;
    car_mode = efcc_pkg::MODE_IDLE;
    heading_up = 1'b0;
    car_floor = HOME4;
    goal_floor = HOME4;
  endtask

  function automatic bit ring_holds(logic [FLOOR_W-1:0] fl);
    for (int i = 0; i < ring_count; i++)
      if (call_ring[QAW'(ring_head + i)] == fl) return 1'b1;
    return 1'b0;
  endfunction

  function automatic cmd_t route_car();
    if (ring_count == 0) begin
      car_mode = efcc_pkg::MODE_IDLE;
      heading_up = 1'b0;
      return CMD_NONE;
    end
    goal_floor = call_ring[ring_head];
    // goal already under the cabin: open doors without moving
    if (goal_floor == car_floor) begin
      car_mode = efcc_pkg::MODE_DOORS;
      return CMD_STOP;
    end
    heading_up = goal_floor > car_floor;
    car_mode = efcc_pkg::MODE_CABIN;
    return CMD_MOVE;
  endfunction

  function automatic efcc_pkg::res_t step_elevator(logic [1:0] op, logic [FLOOR_W-1:0] fl);
    efcc_pkg::res_t r;
    cmd_t cmd;
    r = '0;
    cmd = CMD_NONE;
    case (op)
      efcc_pkg::OP_CALL: begin
        if (int'(fl) <= TOP_FLOOR) begin
          if (fl == car_floor && car_mode == efcc_pkg::MODE_IDLE) begin
            car_mode = efcc_pkg::MODE_DOORS;
            cmd = CMD_STOP;
          end else begin
            if (!ring_holds(fl) && ring_count < efcc_pkg::QFULL) begin
              call_ring[QAW'(ring_head + ring_count)] = fl;
              ring_count++;
            end
            if (car_mode == efcc_pkg::MODE_IDLE) cmd = route_car();
          end
        end
      end
      efcc_pkg::OP_REACHED: begin
        if (car_mode == efcc_pkg::MODE_CABIN) begin
          if (heading_up) begin
            if (car_floor < TOP_FLOOR) car_floor++;
          end else if (car_floor > 0) begin
            car_floor--;
          end
          r.floor_changed = 1'b1;
          if (car_floor != goal_floor) begin
            cmd = CMD_MOVE;
          end else begin
            car_mode = efcc_pkg::MODE_DOORS;
            cmd = CMD_STOP;
          end
        end
      end
      efcc_pkg::OP_CLOSED: begin
        if (car_mode == efcc_pkg::MODE_DOORS) begin
          if (ring_count > 0) begin
            r.serviced_valid = 1'b1;
            r.serviced_floor = call_ring[ring_head];
            ring_head++;
            ring_count--;
          end
          r.free_cabin = 1'b1;
          cmd = route_car();
        end
      end
      default: ;
    endcase
    r.move_cabin = (cmd == CMD_MOVE);
    r.stop_cabin = (cmd == CMD_STOP);
    r.current_floor = car_floor;
    r.ctrl_state = car_mode;
    r.pending_count = ring_count;
    return r;
  endfunction

  function automatic efcc_pkg::res_t status(bit mv, bit st, bit fr, bit sv, int sf, int cur,
                                            efcc_pkg::mode_t m, int cnt);
    efcc_pkg::res_t r;
    r = '0;
    r.move_cabin = mv;
    r.stop_cabin = st;
    r.free_cabin = fr;
    r.serviced_valid = sv;
    r.serviced_floor = FLOOR_W'(sf);
    r.current_floor = FLOOR_W'(cur);
    r.ctrl_state = m;
    r.pending_count = CNT_W'(cnt);
    return r;
  endfunction

  // calls lean toward the current floor and queued floors to hit stop and duplicate cases
  function automatic logic [FLOOR_W-1:0] pick_call_floor();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return car_floor;
    if (r < 4 && ring_count != 0)
      return call_ring[QAW'(ring_head + $urandom_range(0, ring_count - 1))];
    return FLOOR_W'($urandom_range(0, 15));
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // drive one event in bursts with random gaps, return the predicted status on transfer
  task automatic send_event(logic [1:0] op, logic [FLOOR_W-1:0] fl,
                            output efcc_pkg::res_t predicted);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.call_floor <= fl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    predicted = step_elevator(op, fl);
  endtask

  initial begin : receiver
    int stall_left;
    int era_left;
    int stall_pct;
    out_ch.ready = 1'b0;
    stall_left = 0;
    era_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (era_left == 0) begin
        era_left = $urandom_range(200, 800);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 45;
        endcase
      end
      era_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 20);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    efcc_pkg::res_t want;
    int idle_cycles;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        errors++;
        $display("%0t: result with no event waiting, expected nothing got floor %0d state %0d",
                 $time, out_ch.current_floor, out_ch.ctrl_state);
      end else begin
        want = expected_status_q.pop_front();
        check_field("move_cabin", want.move_cabin, out_ch.move_cabin);
        check_field("stop_cabin", want.stop_cabin, out_ch.stop_cabin);
        check_field("free_cabin", want.free_cabin, out_ch.free_cabin);
        check_field("serviced_valid", want.serviced_valid, out_ch.serviced_valid);
        check_field("serviced_floor", want.serviced_floor, out_ch.serviced_floor);
        check_field("floor_changed", want.floor_changed, out_ch.floor_changed);
        check_field("current_floor", want.current_floor, out_ch.current_floor);
        check_field("ctrl_state", want.ctrl_state, out_ch.ctrl_state);
        check_field("pending_count", want.pending_count, out_ch.pending_count);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("elevator_fifo_call_controller verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t plan [$];
    efcc_pkg::res_t predicted;
    logic [1:0] op;
    logic [FLOOR_W-1:0] fl;
    int useful;
    int roll;
    int call_pct;
    int era;
    bit noise;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = efcc_pkg::OP_CALL;
    in_ch.call_floor = '0;
    reset_model();

    // ignored events right after reset, then the stop, free, move and duplicate call paths
    plan.push_back('{efcc_pkg::OP_REACHED, 4'd0, 1, 1'b1,
                     status(0, 0, 0, 0, 0, HOME_FLOOR, efcc_pkg::MODE_IDLE, 0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd15, 1, 1'b1,
                     status(0, 0, 0, 0, 0, HOME_FLOOR, efcc_pkg::MODE_IDLE, 0)});
    plan.push_back('{OP_UNUSED, 4'd15, 1, 1'b1,
                     status(0, 0, 0, 0, 0, HOME_FLOOR, efcc_pkg::MODE_IDLE, 0)});
    plan.push_back('{efcc_pkg::OP_CALL, HOME4, 1, 1'b1,
                     status(0, 1, 0, 0, 0, HOME_FLOOR, efcc_pkg::MODE_DOORS, 0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd0, 1, 1'b1,
                     status(0, 0, 1, 0, 0, HOME_FLOOR, efcc_pkg::MODE_IDLE, 0)});
    plan.push_back('{efcc_pkg::OP_CALL, TOP4, 1, 1'b1,
                     status(1, 0, 0, 0, 0, HOME_FLOOR, efcc_pkg::MODE_CABIN, 1)});
    plan.push_back('{efcc_pkg::OP_CALL, TOP4, 1, 1'b1,
                     status(0, 0, 0, 0, 0, HOME_FLOOR, efcc_pkg::MODE_CABIN, 1)});
    // full trip to the top and back, then goal under the cabin after a service
    plan.push_back('{efcc_pkg::OP_CALL, HOME4, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd7, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_REACHED, 4'd9, TOP_FLOOR - HOME_FLOOR, 1'b0,
                     efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_REACHED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CALL, TOP4, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CALL, 4'd3, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_REACHED, 4'd5, TOP_FLOOR - HOME_FLOOR, 1'b0,
                     efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_REACHED, 4'd0, 3, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CALL, 4'd3, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CALL, 4'd9, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CALL, 4'd3, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{efcc_pkg::OP_CLOSED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});
    plan.push_back('{OP_UNUSED, 4'd0, 1, 1'b0, efcc_pkg::res_t'('0)});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_event(plan[i].op, plan[i].call_fl, predicted);
        expected_status_q.push_back(plan[i].typed ? plan[i].want : predicted);
      end
    end

    // mostly events that fit the current mode, call density shifts so the queue fills at times
    useful = 0;
    era = 0;
    call_pct = 10;
    while (useful < RANDOM_EVENTS) begin
      if (era == 0) begin
        era = $urandom_range(60, 200);
        call_pct = $urandom_range(5, 60);
      end
      era--;
      roll = $urandom_range(0, 99);
      noise = 1'b0;
      op = efcc_pkg::OP_CALL;
      case (car_mode)
        efcc_pkg::MODE_CABIN: begin
          if (roll < call_pct) op = efcc_pkg::OP_CALL;
          else if (roll < 92) op = efcc_pkg::OP_REACHED;
          else noise = 1'b1;
        end
        efcc_pkg::MODE_DOORS: begin
          if (roll < call_pct) op = efcc_pkg::OP_CALL;
          else if (roll < 92) op = efcc_pkg::OP_CLOSED;
          else noise = 1'b1;
        end
        default: begin
          if (roll < 88) op = efcc_pkg::OP_CALL;
          else noise = 1'b1;
        end
      endcase
      if (noise) op = 2'($urandom_range(0, 3));
      fl = (op == efcc_pkg::OP_CALL) ? pick_call_floor() : FLOOR_W'($urandom_range(0, 15));
      send_event(op, fl, predicted);
      expected_status_q.push_back(predicted);
      useful++;
    end
    in_ch.valid <= 1'b0;

    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("elevator_fifo_call_controller verification clean");
    end else begin
      $display("elevator_fifo_call_controller verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/efcc_pkg.sv
rtl/efcc_if.sv
rtl/efcc_qmem.sv
rtl/efcc_ctrl.sv
rtl/elevator_fifo_call_controller.sv
bench/elevator_fifo_call_controller_test.sv
